>>> rtl/core/lcd_escape_command_parser_unit_assert.svh
// Assertion macros shared by the escape command parser RTL.
`ifndef LCD_ESCAPE_COMMAND_PARSER_UNIT_ASSERT_SVH
`define LCD_ESCAPE_COMMAND_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCDEP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");
`define LCDEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");
`else
`define LCDEP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LCDEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lcdep_pkg.sv
// Shared types, byte codes and the default glyph table of the escape command parser.
`timescale 1ns / 1ps
`default_nettype none
package lcdep_pkg;

    localparam int GLYPH_ENTRIES_DEF = 16;
    localparam int GLYPH_ROWS        = 8;
    localparam int ROW_W             = 3;
    localparam logic [ROW_W-1:0] ROW_LAST = 3'd7;

    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] CMD_LOCATE   = 8'h4C; // 'L'
    localparam logic [7:0] CMD_MAP      = 8'h4D; // 'M'
    localparam logic [7:0] CMD_SAVE     = 8'h53; // 'S'
    localparam logic [7:0] CMD_HOME     = 8'h48; // 'H'
    localparam logic [7:0] CMD_CLEAR    = 8'h43; // 'C'
    localparam logic [7:0] CMD_DISP_OFF = 8'h58; // 'X'
    localparam logic [7:0] CMD_DISP_ON  = 8'h4E; // 'N'
    localparam logic [7:0] CMD_BLINK    = 8'h42; // 'B'
    localparam logic [7:0] CMD_CURSOR   = 8'h44; // 'D'
    localparam logic [7:0] CMD_CUR_BLNK = 8'h45; // 'E'
    localparam logic [7:0] CMD_CUR_LEFT = 8'h2D; // '-'
    localparam logic [7:0] CMD_CUR_RGHT = 8'h2B; // '+'
    localparam logic [7:0] CMD_DSP_LEFT = 8'h3C; // '<'
    localparam logic [7:0] CMD_DSP_RGHT = 8'h3E; // '>'

    typedef enum logic [2:0] {
        ACT_CHAR   = 3'd0,
        ACT_HOME   = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_CTRL   = 3'd3,
        ACT_LOCATE = 3'd4,
        ACT_SLOT   = 3'd5,
        ACT_ROW    = 3'd6
    } t_action;

    typedef enum logic [2:0] {
        PS_TEXT,
        PS_CMD,
        PS_LX,
        PS_LY,
        PS_MN,
        PS_MS,
        PS_SN,
        PS_SROW
    } t_parse_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_REDUCE,
        SQ_SEND,
        SQ_READ,
        SQ_LOAD
    } t_seq_state;

    typedef struct packed {
        logic wr_en;
        logic commit;
        logic rd_en;
    } t_store_ctl;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_ctrl_dec;

    localparam logic [7:0] DEFAULT_GLYPHS [16][8] = '{
        '{8'h00, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h18, 8'h18, 8'h18, 8'h18, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h00},
        '{8'h1F, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h1F, 8'h00},
        '{8'h1F, 8'h11, 8'h1F, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h00},
        '{8'h04, 8'h15, 8'h15, 8'h15, 8'h04, 8'h0A, 8'h11, 8'h00},
        '{8'h04, 8'h04, 8'h1D, 8'h06, 8'h0D, 8'h14, 8'h04, 8'h00},
        '{8'h04, 8'h04, 8'h1F, 8'h04, 8'h0E, 8'h15, 8'h04, 8'h00},
        '{8'h04, 8'h0A, 8'h1F, 8'h04, 8'h1F, 8'h0E, 8'h1F, 8'h00},
        '{8'h00, 8'h04, 8'h04, 8'h1F, 8'h04, 8'h04, 8'h1F, 8'h00},
        '{8'h08, 8'h0F, 8'h02, 8'h0F, 8'h0A, 8'h1F, 8'h02, 8'h00},
        '{8'h00, 8'h0E, 8'h15, 8'h15, 8'h15, 8'h0E, 8'h00, 8'h00},
        '{8'h00, 8'h0E, 8'h13, 8'h15, 8'h19, 8'h0E, 8'h00, 8'h00}
    };

    function automatic logic [7:0] default_row(input logic [3:0] glyph,
                                               input logic [ROW_W-1:0] row);
        return DEFAULT_GLYPHS[glyph][row];
    endfunction

    // Maps a display or cursor control letter to its control index.
    function automatic t_ctrl_dec ctrl_decode(input logic [7:0] code);
        t_ctrl_dec dec;
        dec.hit = 1'b1;
        dec.idx = 4'd0;
        case (code)
            CMD_DISP_OFF: dec.idx = 4'd0;
            CMD_DISP_ON:  dec.idx = 4'd1;
            CMD_BLINK:    dec.idx = 4'd2;
            CMD_CURSOR:   dec.idx = 4'd3;
            CMD_CUR_BLNK: dec.idx = 4'd4;
            CMD_CUR_LEFT: dec.idx = 4'd5;
            CMD_CUR_RGHT: dec.idx = 4'd6;
            CMD_DSP_LEFT: dec.idx = 4'd7;
            CMD_DSP_RGHT: dec.idx = 4'd8;
            default:      dec.hit = 1'b0;
        endcase
        return dec;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lcd_escape_command_parser_unit.sv
// Top level of the escape command parser for a character display.
// A result is registered when its request is accepted and is presented in the cycle after.
// Requests do not overlap: a text byte or one-result command holds the block until its result is
// taken; the store index request of map or save holds it while the shared subtractor reduces it.
// A map slot request gives the slot result, then eight row results, each read from the store first.
// Reset: parser returns to text mode; the store reads the default table at once.
`timescale 1ns / 1ps
`default_nettype none
`include "lcd_escape_command_parser_unit_assert.svh"
module lcd_escape_command_parser_unit #(
    parameter int GLYPH_ENTRIES = lcdep_pkg::GLYPH_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [2:0] action, [10:3] arg_a, [18:11] arg_b, zeros
    output logic             o_m_tlast    // last result caused by the request
);
    localparam int ENTRY_W    = $clog2(GLYPH_ENTRIES);
    // Highest shift of the entry count used by the restoring reduction of an 8-bit index.
    localparam int REDUCE_TOP = $clog2((256 + GLYPH_ENTRIES - 1) / GLYPH_ENTRIES) - 1;
    localparam int STEP_W     = $clog2(REDUCE_TOP + 1);

    lcdep_pkg::t_parse_state r_parse, n_parse;
    lcdep_pkg::t_seq_state   r_seq, n_seq;
    logic [7:0]              r_held, n_held;
    logic [lcdep_pkg::ROW_W-1:0] r_row, n_row;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_more, n_more;
    logic                    r_out_valid, n_out_valid;
    lcdep_pkg::t_action      r_out_action, n_out_action;
    logic [7:0]              r_out_a, n_out_a;
    logic [7:0]              r_out_b, n_out_b;
    logic                    r_out_last, n_out_last;

    logic                    s_accept;
    lcdep_pkg::t_ctrl_dec    ctrl;
    lcdep_pkg::t_store_ctl   store_ctl;
    logic [7:0]              rd_data;
    logic [8:0]              divisor;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign ctrl     = lcdep_pkg::ctrl_decode(i_s_tdata);
    assign divisor  = 9'(GLYPH_ENTRIES) << r_step;

    lcdep_glyph_store #(
        .GLYPH_ENTRIES(GLYPH_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_entry   (r_held[ENTRY_W-1:0]),
        .i_row     (r_row),
        .i_wr_data (i_s_tdata),
        .o_rd_data (rd_data)
    );

    // Next state: the parser state advances per accepted byte; the sequencer runs the
    // index reduction and walks the eight rows of a mapped glyph.
    always_comb begin
        n_parse      = r_parse;
        n_seq        = r_seq;
        n_held       = r_held;
        n_row        = r_row;
        n_step       = r_step;
        n_more       = r_more;
        n_out_valid  = r_out_valid;
        n_out_action = r_out_action;
        n_out_a      = r_out_a;
        n_out_b      = r_out_b;
        n_out_last   = r_out_last;
        case (r_seq)
            lcdep_pkg::SQ_IDLE: begin
                if (s_accept) begin
                    case (r_parse)
                        lcdep_pkg::PS_TEXT: begin
                            if (i_s_tdata == lcdep_pkg::ESC_BYTE) begin
                                n_parse = lcdep_pkg::PS_CMD;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_action = lcdep_pkg::ACT_CHAR;
                                n_out_a      = i_s_tdata;
                                n_out_b      = 8'd0;
                                n_out_last   = 1'b1;
                                n_more       = 1'b0;
                                n_seq        = lcdep_pkg::SQ_SEND;
                            end
                        end
                        lcdep_pkg::PS_CMD: begin
                            case (i_s_tdata)
                                lcdep_pkg::CMD_LOCATE: n_parse = lcdep_pkg::PS_LX;
                                lcdep_pkg::CMD_MAP:    n_parse = lcdep_pkg::PS_MN;
                                lcdep_pkg::CMD_SAVE:   n_parse = lcdep_pkg::PS_SN;
                                lcdep_pkg::CMD_HOME, lcdep_pkg::CMD_CLEAR: begin
                                    n_parse      = lcdep_pkg::PS_TEXT;
                                    n_out_valid  = 1'b1;
                                    n_out_action = (i_s_tdata == lcdep_pkg::CMD_HOME)
                                                   ? lcdep_pkg::ACT_HOME
                                                   : lcdep_pkg::ACT_CLEAR;
                                    n_out_a      = 8'd0;
                                    n_out_b      = 8'd0;
                                    n_out_last   = 1'b1;
                                    n_more       = 1'b0;
                                    n_seq        = lcdep_pkg::SQ_SEND;
                                end
                                default: begin
                                    // Unknown letters are dropped and command mode holds.
                                    if (ctrl.hit) begin
                                        n_parse      = lcdep_pkg::PS_TEXT;
                                        n_out_valid  = 1'b1;
                                        n_out_action = lcdep_pkg::ACT_CTRL;
                                        n_out_a      = 8'(ctrl.idx);
                                        n_out_b      = 8'd0;
                                        n_out_last   = 1'b1;
                                        n_more       = 1'b0;
                                        n_seq        = lcdep_pkg::SQ_SEND;
                                    end
                                end
                            endcase
                        end
                        lcdep_pkg::PS_LX: begin
                            n_held  = i_s_tdata;
                            n_parse = lcdep_pkg::PS_LY;
                        end
                        lcdep_pkg::PS_LY: begin
                            n_parse      = lcdep_pkg::PS_TEXT;
                            n_out_valid  = 1'b1;
                            n_out_action = lcdep_pkg::ACT_LOCATE;
                            n_out_a      = r_held;
                            n_out_b      = i_s_tdata;
                            n_out_last   = 1'b1;
                            n_more       = 1'b0;
                            n_seq        = lcdep_pkg::SQ_SEND;
                        end
                        lcdep_pkg::PS_MN, lcdep_pkg::PS_SN: begin
                            n_held  = i_s_tdata;
                            n_row   = '0;
                            n_step  = STEP_W'(REDUCE_TOP);
                            n_seq   = lcdep_pkg::SQ_REDUCE;
                            n_parse = (r_parse == lcdep_pkg::PS_MN) ? lcdep_pkg::PS_MS
                                                                    : lcdep_pkg::PS_SROW;
                        end
                        lcdep_pkg::PS_MS: begin
                            n_parse      = lcdep_pkg::PS_TEXT;
                            n_out_valid  = 1'b1;
                            n_out_action = lcdep_pkg::ACT_SLOT;
                            n_out_a      = {5'd0, i_s_tdata[2:0]};
                            n_out_b      = 8'd0;
                            n_out_last   = 1'b0;
                            n_more       = 1'b1;
                            n_row        = '0;
                            n_seq        = lcdep_pkg::SQ_SEND;
                        end
                        lcdep_pkg::PS_SROW: begin
                            // The row is written straight into the store entry.
                            n_row = r_row + 1'b1;
                            if (r_row == lcdep_pkg::ROW_LAST) begin
                                n_parse = lcdep_pkg::PS_TEXT;
                            end
                        end
                        default: n_parse = lcdep_pkg::PS_TEXT;
                    endcase
                end
            end
            lcdep_pkg::SQ_REDUCE: begin
                // One restoring compare-and-subtract step per cycle.
                if ({1'b0, r_held} >= divisor) begin
                    n_held = r_held - divisor[7:0];
                end
                if (r_step == '0) begin
                    n_seq = lcdep_pkg::SQ_IDLE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            lcdep_pkg::SQ_SEND: begin
                if (i_m_tready) begin
                    n_out_valid = 1'b0;
                    n_seq       = r_more ? lcdep_pkg::SQ_READ : lcdep_pkg::SQ_IDLE;
                end
            end
            lcdep_pkg::SQ_READ: n_seq = lcdep_pkg::SQ_LOAD;
            lcdep_pkg::SQ_LOAD: begin
                n_out_valid  = 1'b1;
                n_out_action = lcdep_pkg::ACT_ROW;
                n_out_a      = rd_data;
                n_out_b      = 8'd0;
                n_out_last   = (r_row == lcdep_pkg::ROW_LAST);
                n_more       = (r_row != lcdep_pkg::ROW_LAST);
                n_row        = r_row + 1'b1;
                n_seq        = lcdep_pkg::SQ_SEND;
            end
            default: n_seq = lcdep_pkg::SQ_IDLE;
        endcase
    end

    // Outputs: requests are taken only while the sequencer is idle.
    always_comb begin
        o_s_tready         = (r_seq == lcdep_pkg::SQ_IDLE);
        store_ctl.wr_en    = s_accept && (r_parse == lcdep_pkg::PS_SROW);
        store_ctl.commit   = store_ctl.wr_en && (r_row == lcdep_pkg::ROW_LAST);
        store_ctl.rd_en    = (r_seq == lcdep_pkg::SQ_READ);
        o_m_tvalid         = r_out_valid;
        o_m_tdata          = {5'd0, r_out_b, r_out_a, r_out_action};
        o_m_tlast          = r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse     <= lcdep_pkg::PS_TEXT;
            r_seq       <= lcdep_pkg::SQ_IDLE;
            r_out_valid <= 1'b0;
            r_more      <= 1'b0;
            r_row       <= '0;
            r_step      <= '0;
            r_held      <= 8'd0;
        end else begin
            r_parse     <= n_parse;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            r_more      <= n_more;
            r_row       <= n_row;
            r_step      <= n_step;
            r_held      <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_action <= n_out_action;
        r_out_a      <= n_out_a;
        r_out_b      <= n_out_b;
        r_out_last   <= n_out_last;
    end

    `LCDEP_ASSERT_IMPL(a_ready_no_pending, i_clk, i_rst_n, o_s_tready, !r_out_valid)
    `LCDEP_ASSERT_NEXT(a_slot_first, i_clk, i_rst_n, s_accept && r_parse == lcdep_pkg::PS_MS, r_out_valid && r_out_action == lcdep_pkg::ACT_SLOT && !r_out_last)
    `LCDEP_ASSERT_NEXT(a_index_reduced, i_clk, i_rst_n, r_seq == lcdep_pkg::SQ_REDUCE && r_step == '0, r_held < 8'(GLYPH_ENTRIES))
    `LCDEP_ASSERT_IMPL(a_write_only_saving, i_clk, i_rst_n, store_ctl.wr_en, r_seq == lcdep_pkg::SQ_IDLE && !store_ctl.rd_en)

endmodule
`default_nettype wire

>>> rtl/core/lcdep_glyph_store.sv
// Glyph store: one-port-write, registered-read memory with per-entry valid bits over the default table.
`timescale 1ns / 1ps
`default_nettype none
module lcdep_glyph_store #(
    parameter int GLYPH_ENTRIES = lcdep_pkg::GLYPH_ENTRIES_DEF,
    localparam int ENTRY_W = $clog2(GLYPH_ENTRIES)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lcdep_pkg::t_store_ctl         i_ctl,
    input  wire logic [ENTRY_W-1:0]            i_entry,
    input  wire logic [lcdep_pkg::ROW_W-1:0]   i_row,
    input  wire logic [7:0]                    i_wr_data,
    output logic [7:0]                         o_rd_data
);
    localparam int DEPTH  = GLYPH_ENTRIES * lcdep_pkg::GLYPH_ROWS;
    localparam int ADDR_W = ENTRY_W + lcdep_pkg::ROW_W;

    logic [7:0]               r_mem [DEPTH];
    logic [GLYPH_ENTRIES-1:0] r_valid;
    logic [7:0]               r_mem_q;
    logic [7:0]               r_dflt_q;
    logic                     r_vld_q;
    logic [ADDR_W-1:0]        addr;

    assign addr = {i_entry, i_row};

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_mem_q  <= r_mem[addr];
            r_dflt_q <= lcdep_pkg::default_row(4'(i_entry), i_row);
            r_vld_q  <= r_valid[i_entry];
        end
    end

    // An entry reads from the default table until a save has filled all of its rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.commit) begin
            r_valid[i_entry] <= 1'b1;
        end
    end

    assign o_rd_data = r_vld_q ? r_mem_q : r_dflt_q;

endmodule
`default_nettype wire
